// ===== sv/sbf_pkg.sv =====
// ----------------------------------------------------------------------------
// sbf_pkg
// Shared widths, register indexes, filter mode codes and size clamping for
// the 3x3 streaming pass-through / blur / Sobel filter.
// ----------------------------------------------------------------------------
package sbf_pkg;

    localparam int MAX_WIDTH  = 512;
    localparam int MAX_HEIGHT = 4096;

    localparam int PIX_W    = 8;
    localparam int NIB_W    = 4;
    localparam int COL_W    = $clog2(MAX_WIDTH);
    localparam int ROW_W    = $clog2(MAX_HEIGHT);
    localparam int WID_W    = COL_W + 1;
    localparam int HGT_W    = ROW_W + 1;
    localparam int MODE_W   = 2;
    localparam int THR_W    = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = HGT_W;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FILTER_MODE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_EDGE_THRESHOLD = 2'd3;

    // filter modes
    localparam logic [MODE_W-1:0] MODE_PASS = 2'd0;
    localparam logic [MODE_W-1:0] MODE_BLUR = 2'd1;
    localparam logic [MODE_W-1:0] MODE_EDGE = 2'd2;

    // reset values
    localparam logic [MODE_W-1:0] RST_MODE      = MODE_PASS;
    localparam logic [WID_W-1:0]  RST_WIDTH     = 10'd320;
    localparam logic [HGT_W-1:0]  RST_HEIGHT    = 13'd240;
    localparam logic [THR_W-1:0]  RST_THRESHOLD = 8'd18;

    localparam int MIN_SIZE = 3;

    // floor(s/9) for s <= 135 as (s * 57) >> 9
    localparam int DIV9_MUL   = 57;
    localparam int DIV9_SHIFT = 9;

    // window position of the delayed pixel
    typedef struct packed {
        logic valid;
        logic interior;
    } sbf_pos_t;

    function automatic logic [WID_W-1:0] clamp_width(input logic [WID_W-1:0] v);
        logic [WID_W-1:0] r;
        if (v < WID_W'(MIN_SIZE))
            r = WID_W'(MIN_SIZE);
        else if (v > WID_W'(MAX_WIDTH))
            r = WID_W'(MAX_WIDTH);
        else
            r = v;
        return r;
    endfunction

    function automatic logic [HGT_W-1:0] clamp_height(input logic [HGT_W-1:0] v);
        logic [HGT_W-1:0] r;
        if (v < HGT_W'(MIN_SIZE))
            r = HGT_W'(MIN_SIZE);
        else if (v > HGT_W'(MAX_HEIGHT))
            r = HGT_W'(MAX_HEIGHT);
        else
            r = v;
        return r;
    endfunction

endpackage

// ===== sv/sbf_stream_if.sv =====
// ----------------------------------------------------------------------------
// sbf_pixel_if / sbf_result_if
// Valid/ready channels for incoming grey pixels and filtered results.
// ----------------------------------------------------------------------------
interface sbf_pixel_if import sbf_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel_in;
    logic             frame_start;

    modport source (output valid, output pixel_in, output frame_start, input ready);
    modport sink   (input valid, input pixel_in, input frame_start, output ready);
endinterface

interface sbf_result_if import sbf_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel_out;
    logic             out_valid_pos;

    modport source (output valid, output pixel_out, output out_valid_pos, input ready);
    modport sink   (input valid, input pixel_out, input out_valid_pos, output ready);
endinterface

// ===== sv/sbf_raster_ctrl.sv =====
// ----------------------------------------------------------------------------
// sbf_raster_ctrl
// Column/row counters; gives the line store address and classifies the
// delayed (window centre) position of each transaction.
// ----------------------------------------------------------------------------
module sbf_raster_ctrl import sbf_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             accept,
    input  logic             frame_start,
    input  logic [WID_W-1:0] frame_width,
    input  logic [HGT_W-1:0] frame_height,
    output logic [COL_W-1:0] col,
    output sbf_pos_t         pos
);

    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic [ROW_W-1:0] row;
    logic [WID_W-1:0] w;
    logic [HGT_W-1:0] h;
    logic [WID_W-1:0] col_ext;
    logic [HGT_W-1:0] row_ext;

    assign w       = clamp_width(frame_width);
    assign h       = clamp_height(frame_height);
    assign col     = frame_start ? '0 : col_reg;
    assign row     = frame_start ? '0 : row_reg;
    assign col_ext = {1'b0, col};
    assign row_ext = {1'b0, row};

    always_comb
    begin
        // centre one line and one pixel back; column 0 wraps to the line before
        pos.valid    = ((col != '0) && (row != '0)) || ((col == '0) && (row >= ROW_W'(2)));
        pos.interior = (col >= COL_W'(2)) && (row >= ROW_W'(2)) && (col_ext < w) && (row_ext < h);
    end

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (accept)
        begin
            if (col_ext + WID_W'(1) >= w)
            begin
                col_next = '0;
                row_next = (row_ext + HGT_W'(1) >= h) ? '0 : row + ROW_W'(1);
            end
            else
            begin
                col_next = col + COL_W'(1);
                row_next = row;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

// ===== sv/sbf_line_store.sv =====
// ----------------------------------------------------------------------------
// sbf_line_store
// Both line stores in one synchronous RAM, {upper, lower} per column.
// Read on accept, write back when the window advances;
// a same-column read at the write edge is forwarded. Cleared after reset.
// ----------------------------------------------------------------------------
module sbf_line_store import sbf_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             rd_en,
    input  logic [COL_W-1:0] rd_addr,
    input  logic             wr_en,
    input  logic [NIB_W-1:0] wr_nib,
    output logic [NIB_W-1:0] upper_nib,
    output logic [NIB_W-1:0] lower_nib,
    output logic             clearing
);

    logic [2*NIB_W-1:0] mem [MAX_WIDTH];
    logic [2*NIB_W-1:0] rdata_reg;
    logic [2*NIB_W-1:0] byp_data_reg;
    logic [2*NIB_W-1:0] rd_eff;
    logic [2*NIB_W-1:0] wr_data;
    logic [COL_W-1:0]   addr_reg;
    logic               byp_reg, byp_next;
    logic [COL_W-1:0]   clr_addr_reg, clr_addr_next;
    logic               clearing_reg, clearing_next;

    assign rd_eff    = byp_reg ? byp_data_reg : rdata_reg;
    // lower line moves up, new nibble becomes the lower line
    assign wr_data   = {rd_eff[NIB_W-1:0], wr_nib};
    assign upper_nib = rd_eff[2*NIB_W-1:NIB_W];
    assign lower_nib = rd_eff[NIB_W-1:0];
    assign clearing  = clearing_reg;

    always_ff @(posedge clk)
    begin
        if (clearing_reg)
            mem[clr_addr_reg] <= '0;
        else if (wr_en)
            mem[addr_reg] <= wr_data;
        if (rd_en)
        begin
            rdata_reg    <= mem[rd_addr];
            addr_reg     <= rd_addr;
            byp_data_reg <= wr_data;
        end
    end

    always_comb
    begin
        byp_next      = rd_en ? (wr_en && (addr_reg == rd_addr)) : byp_reg;
        clr_addr_next = clearing_reg ? clr_addr_reg + COL_W'(1) : clr_addr_reg;
        clearing_next = clearing_reg && (clr_addr_reg != COL_W'(MAX_WIDTH - 1));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byp_reg      <= 1'b0;
            clr_addr_reg <= '0;
            clearing_reg <= 1'b1;
        end
        else
        begin
            byp_reg      <= byp_next;
            clr_addr_reg <= clr_addr_next;
            clearing_reg <= clearing_next;
        end
    end

endmodule

// ===== sv/sbf_window_filter.sv =====
// ----------------------------------------------------------------------------
// sbf_window_filter
// 3x3 window of nibbles, pass / blur / Sobel datapath and result register.
// ----------------------------------------------------------------------------
module sbf_window_filter import sbf_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              advance,
    input  logic [NIB_W-1:0]  nib,
    input  logic [NIB_W-1:0]  upper_nib,
    input  logic [NIB_W-1:0]  lower_nib,
    input  sbf_pos_t          pos,
    input  logic [MODE_W-1:0] filter_mode,
    input  logic [THR_W-1:0]  edge_threshold,
    output logic [PIX_W-1:0]  pixel_out,
    output logic              out_valid_pos
);

    localparam int SUM_W  = 8;
    localparam int PROD_W = SUM_W + 6;
    localparam int G_W    = 8;

    logic [NIB_W-1:0] win_reg [9];
    logic [NIB_W-1:0] k [9];
    logic [SUM_W-1:0] sum;
    logic [PROD_W-1:0] prod;
    logic [PIX_W-1:0] blur;
    logic signed [G_W-1:0] gx, gy;
    logic [G_W-1:0] ax, ay;
    logic [PIX_W-1:0] mag;
    logic [PIX_W-1:0] result;
    logic [PIX_W-1:0] pixel_out_reg;
    logic             pos_valid_reg;

    // window after this transaction's shift, row-major, top row oldest
    always_comb
    begin
        k[0] = win_reg[1];
        k[1] = win_reg[2];
        k[2] = upper_nib;
        k[3] = win_reg[4];
        k[4] = win_reg[5];
        k[5] = lower_nib;
        k[6] = win_reg[7];
        k[7] = win_reg[8];
        k[8] = nib;
    end

    always_comb
    begin
        sum = '0;
        for (int i = 0; i < 9; i++)
            sum = sum + SUM_W'(k[i]);
    end

    assign prod = PROD_W'(sum) * PROD_W'(DIV9_MUL);
    assign blur = PIX_W'(prod >> DIV9_SHIFT);

    always_comb
    begin
        gx = G_W'(k[0]) - G_W'(k[2]) + (G_W'(k[3]) <<< 1) - (G_W'(k[5]) <<< 1)
           + G_W'(k[6]) - G_W'(k[8]);
        gy = G_W'(k[0]) + (G_W'(k[1]) <<< 1) + G_W'(k[2])
           - G_W'(k[6]) - (G_W'(k[7]) <<< 1) - G_W'(k[8]);
        ax = gx[G_W-1] ? G_W'(-gx) : G_W'(gx);
        ay = gy[G_W-1] ? G_W'(-gy) : G_W'(gy);
        mag = PIX_W'(ax + ay);
    end

    always_comb
    begin
        result = '0;
        if (pos.valid)
        begin
            unique case (filter_mode)
                MODE_PASS: result = PIX_W'(k[4]);
                MODE_BLUR: result = pos.interior ? blur : '0;
                MODE_EDGE: result = (pos.interior && (mag >= edge_threshold)) ? mag : '0;
                default:   result = '0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 9; i++)
                win_reg[i] <= '0;
        end
        else if (advance)
        begin
            for (int i = 0; i < 9; i++)
                win_reg[i] <= k[i];
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            pixel_out_reg <= result;
            pos_valid_reg <= pos.valid;
        end
    end

    assign pixel_out     = pixel_out_reg;
    assign out_valid_pos = pos_valid_reg;

endmodule

// ===== sv/sobel_blur_3x3_filter_unit.sv =====
// ----------------------------------------------------------------------------
// sobel_blur_3x3_filter_unit
// Streaming 3x3 filter on the upper nibble of grey pixels in raster order:
// pass-through, box blur (sum / 9) or thresholded |Sobel X| + |Sobel Y|.
// ----------------------------------------------------------------------------
// Usage:
//   pixel  : sink channel, one grey byte per transaction plus frame_start on
//            the first pixel of each frame.
//   result : source channel, one transaction per pixel transaction, giving
//            the filtered value of the pixel frame_width+1 places earlier
//            and whether that position lies inside the current frame.
//   cfg_*  : register writes (mode, width, height, threshold), taken on any
//            edge with cfg_wr_en high; change them only while idle.
// Throughput is one pixel per clock while the result sink keeps up. The edge
//   that accepts a pixel reads the line store RAM; the advancing edge writes
//   it back, shifts the window and loads the result register.
// After reset the line store RAM is swept to zero, one column per cycle,
//   across all 512 columns; pixel.ready stays low meanwhile.
// If the result sink stalls, the result register holds and the read stage
//   holds behind it; pixel.ready drops when both are full or while clearing.
// ----------------------------------------------------------------------------
module sobel_blur_3x3_filter_unit import sbf_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    sbf_pixel_if.sink             pixel,
    sbf_result_if.source          result,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    // configuration registers
    logic [MODE_W-1:0] filter_mode_reg;
    logic [WID_W-1:0]  frame_width_reg;
    logic [HGT_W-1:0]  frame_height_reg;
    logic [THR_W-1:0]  edge_threshold_reg;

    // handshake / pipeline control
    logic       accept;
    logic       advance;
    logic       out_free;
    logic       clearing;
    logic       s1_valid_reg, s1_valid_next;
    logic       out_valid_reg, out_valid_next;

    // read stage payload
    logic [NIB_W-1:0] s1_nib_reg;
    sbf_pos_t         s1_pos_reg;

    logic [COL_W-1:0] col;
    sbf_pos_t         pos;
    logic [NIB_W-1:0] upper_nib;
    logic [NIB_W-1:0] lower_nib;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filter_mode_reg    <= RST_MODE;
            frame_width_reg    <= RST_WIDTH;
            frame_height_reg   <= RST_HEIGHT;
            edge_threshold_reg <= RST_THRESHOLD;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_FILTER_MODE:    filter_mode_reg    <= cfg_data[MODE_W-1:0];
                REG_FRAME_WIDTH:    frame_width_reg    <= cfg_data[WID_W-1:0];
                REG_FRAME_HEIGHT:   frame_height_reg   <= cfg_data[HGT_W-1:0];
                REG_EDGE_THRESHOLD: edge_threshold_reg <= cfg_data[THR_W-1:0];
            endcase
        end
    end

    // result register frees when empty or taken this cycle
    assign out_free    = !out_valid_reg || result.ready;
    assign advance     = s1_valid_reg && out_free;
    assign pixel.ready = !clearing && (!s1_valid_reg || out_free);
    assign accept      = pixel.valid && pixel.ready;

    always_comb
    begin
        s1_valid_next  = accept ? 1'b1 : (advance ? 1'b0 : s1_valid_reg);
        out_valid_next = advance ? 1'b1 : (result.ready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_nib_reg <= pixel.pixel_in[PIX_W-1:PIX_W-NIB_W];
            s1_pos_reg <= pos;
        end
    end

    sbf_raster_ctrl u_raster (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .frame_start  (pixel.frame_start),
        .frame_width  (frame_width_reg),
        .frame_height (frame_height_reg),
        .col          (col),
        .pos          (pos)
    );

    sbf_line_store u_line_store (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd_en     (accept),
        .rd_addr   (col),
        .wr_en     (advance),
        .wr_nib    (s1_nib_reg),
        .upper_nib (upper_nib),
        .lower_nib (lower_nib),
        .clearing  (clearing)
    );

    sbf_window_filter u_filter (
        .clk            (clk),
        .rst_n          (rst_n),
        .advance        (advance),
        .nib            (s1_nib_reg),
        .upper_nib      (upper_nib),
        .lower_nib      (lower_nib),
        .pos            (s1_pos_reg),
        .filter_mode    (filter_mode_reg),
        .edge_threshold (edge_threshold_reg),
        .pixel_out      (result.pixel_out),
        .out_valid_pos  (result.out_valid_pos)
    );

    assign result.valid = out_valid_reg;

endmodule
